[design/cluster_run_extent_merger_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cluster run extent merger
// Concurrent checks sampled on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_RUN_EXTENT_MERGER_UNIT_ASSERT_SVH
`define CLUSTER_RUN_EXTENT_MERGER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CREM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CREM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/crem_pkg.sv]
// ----------------------------------------------------------------------------
// Cluster run extent merger package
// Widths, register indexes and the records passed between the merger parts.
// ----------------------------------------------------------------------------
package crem_pkg;

	localparam int CLUSTER_W = 32;
	localparam int COUNT_W   = 32;
	localparam int SIZE_W    = 26;
	localparam int AREA_W    = 48;
	localparam int EXT_W     = 64;
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 4;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	// Register index, taken from paddr bit 3 (registers sit 8 bytes apart).
	typedef enum logic {
		REG_CLUSTER_BYTES    = 1'b0,
		REG_DATA_AREA_OFFSET = 1'b1
	} reg_idx_t;

	// One closed run waiting to be turned into a byte extent.
	typedef struct packed {
		logic [CLUSTER_W-1:0] start;
		logic [COUNT_W-1:0]   count;
		logic                 last;
	} run_rec_t;

	// Up to two runs closed by one accepted cluster.
	typedef struct packed {
		logic [1:0] num;
		run_rec_t   rec0;
		run_rec_t   rec1;
	} run_push_t;

	typedef struct packed {
		logic              empty;
		logic              room;
		logic [FCNT_W-1:0] count;
	} fifo_status_t;

endpackage

[design/crem_rec_fifo.sv]
// ----------------------------------------------------------------------------
// Run record queue
// Four-entry register queue taking zero, one or two records per cycle and
// giving one record per cycle on pop.
// ----------------------------------------------------------------------------
module crem_rec_fifo
	import crem_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  run_push_t    push,
	input  logic         pop,
	output run_rec_t     head,
	output fifo_status_t status
);

	run_rec_t          mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FCNT_W-1:0] cnt_q;
	logic [PTR_W-1:0]  wr_ptr_nx;

	assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_ptr_q] <= push.rec0;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.rec1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + FCNT_W'(push.num) - FCNT_W'(pop);
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.empty = (cnt_q == '0);
	// Room for two more records, the most one cluster can close.
	assign status.room  = (cnt_q <= FCNT_W'(FIFO_DEPTH - 2));
	assign status.count = cnt_q;

endmodule

[design/crem_extent_calc.sv]
// ----------------------------------------------------------------------------
// Extent arithmetic
// Turns a run record into a byte offset and a byte length.
// ----------------------------------------------------------------------------
module crem_extent_calc
	import crem_pkg::*;
(
	input  run_rec_t          rec,
	input  logic [SIZE_W-1:0] cluster_bytes,
	input  logic [AREA_W-1:0] data_area_offset,
	output logic [EXT_W-1:0]  extent_offset,
	output logic [EXT_W-1:0]  extent_length
);

	logic signed [CLUSTER_W:0]          start_term;
	logic signed [SIZE_W:0]             size_s;
	logic signed [CLUSTER_W+SIZE_W+1:0] off_prod;
	logic [COUNT_W+SIZE_W-1:0]          len_prod;

	// With a data area the start is relative to cluster two and may go
	// negative; without one the plain start number is used.
	always_comb begin
		if (data_area_offset != '0) begin
			start_term = $signed({1'b0, rec.start}) - $signed((CLUSTER_W+1)'(2));
		end else begin
			start_term = $signed({1'b0, rec.start});
		end
	end

	assign size_s   = $signed({1'b0, cluster_bytes});
	assign off_prod = start_term * size_s;
	assign len_prod = rec.count * cluster_bytes;

	assign extent_offset = EXT_W'(off_prod) + EXT_W'(data_area_offset);
	assign extent_length = EXT_W'(len_prod);

endmodule

[design/cluster_run_extent_merger_unit.sv]
// ----------------------------------------------------------------------------
// Cluster run extent merger
// Merges a chain of cluster numbers into runs of adjacent clusters and emits
// each run as a byte offset and byte length on the volume.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ---------------------------------------
//  input     in_valid/in_ready    cluster, last_in
//  output    out_valid/out_ready  extent_offset, extent_length, last_out
//  config    APB psel/penable     paddr, pwdata, prdata (64-bit data)
//
// One cluster word is taken per cycle while the run queue has room for two
// records, so a chain of clusters streams at one word per clock.
// A result word passes from the run queue into the output register, which
// captures the extent computed on the queue head.
// A cluster that both breaks a run and ends the chain yields two result
// words; the output drains one per cycle, and the input stalls only when the
// queue is nearly full. Output stalls back up into the queue and then input.
// Reset clears the run state, the queue and the output valid, and restores
// cluster_bytes to 512 and data_area_offset to zero.
//
module cluster_run_extent_merger_unit
	import crem_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CLUSTER_W-1:0] cluster,
	input  logic                 last_in,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [EXT_W-1:0]     extent_offset,
	output logic [EXT_W-1:0]     extent_length,
	output logic                 last_out,

	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	`include "cluster_run_extent_merger_unit_assert.svh"

	// Configuration registers. Writes decode on address bit 3 only, so each
	// register occupies an 8-byte slot.
	logic [SIZE_W-1:0] cluster_bytes_q;
	logic [AREA_W-1:0] data_area_offset_q;
	logic              cfg_write;
	reg_idx_t          cfg_idx;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_idx   = reg_idx_t'(paddr[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_bytes_q    <= SIZE_RESET;
			data_area_offset_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_CLUSTER_BYTES:    cluster_bytes_q    <= pwdata[SIZE_W-1:0];
				REG_DATA_AREA_OFFSET: data_area_offset_q <= pwdata[AREA_W-1:0];
				default:              ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_CLUSTER_BYTES:    prdata = DATA_W'(cluster_bytes_q);
			REG_DATA_AREA_OFFSET: prdata = DATA_W'(data_area_offset_q);
			default:              prdata = '0;
		endcase
	end

	// Run tracking. The open run lives in these registers; a cluster that
	// does not follow the previous one closes it into the queue.
	logic [CLUSTER_W-1:0] prev_cluster_q;
	logic [CLUSTER_W-1:0] run_start_q;
	logic [COUNT_W-1:0]   run_count_q;
	logic                 run_open_q;

	logic                 in_fire;
	logic                 follows;
	logic                 breaks;
	logic [CLUSTER_W-1:0] start_nx;
	logic [COUNT_W-1:0]   count_nx;
	run_push_t            push;
	fifo_status_t         fst;
	run_rec_t             head;
	logic                 pop;

	assign in_ready = fst.room;
	assign in_fire  = in_valid && in_ready;

	// Adjacency is tested modulo 2^32, so cluster zero follows the all-ones
	// cluster number.
	assign follows = ((cluster - prev_cluster_q) == CLUSTER_W'(1));
	assign breaks  = run_open_q && !follows;

	always_comb begin
		if (run_open_q && follows) begin
			start_nx = run_start_q;
			// The count saturates rather than wrapping.
			count_nx = (run_count_q == '1) ? run_count_q : run_count_q + COUNT_W'(1);
		end else begin
			start_nx = cluster;
			count_nx = COUNT_W'(1);
		end
	end

	// When the run breaks, the old run goes first and the chain's final run,
	// if last_in is set, goes second.
	always_comb begin
		push.rec0.start = breaks ? run_start_q : start_nx;
		push.rec0.count = breaks ? run_count_q : count_nx;
		push.rec0.last  = !breaks;
		push.rec1.start = start_nx;
		push.rec1.count = count_nx;
		push.rec1.last  = 1'b1;
		if (!in_fire) begin
			push.num = 2'd0;
		end else begin
			push.num = 2'(breaks) + 2'(last_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cluster_q <= '0;
			run_start_q    <= '0;
			run_count_q    <= '0;
			run_open_q     <= 1'b0;
		end else if (in_fire) begin
			prev_cluster_q <= cluster;
			run_start_q    <= start_nx;
			run_count_q    <= count_nx;
			run_open_q     <= !last_in;
		end
	end

	crem_rec_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.status (fst)
	);

	// Extent arithmetic on the queue head, registered into the output stage.
	logic [EXT_W-1:0] offset_c;
	logic [EXT_W-1:0] length_c;
	logic             out_valid_q;
	logic [EXT_W-1:0] extent_offset_q;
	logic [EXT_W-1:0] extent_length_q;
	logic             last_out_q;

	crem_extent_calc u_calc (
		.rec              (head),
		.cluster_bytes    (cluster_bytes_q),
		.data_area_offset (data_area_offset_q),
		.extent_offset    (offset_c),
		.extent_length    (length_c)
	);

	assign pop = !fst.empty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= !fst.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			extent_offset_q <= offset_c;
			extent_length_q <= length_c;
			last_out_q      <= head.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign extent_offset = extent_offset_q;
	assign extent_length = extent_length_q;
	assign last_out      = last_out_q;

	`CREM_ASSERT_SAME(a_push_has_room, push.num != 2'd0, fst.room, "queue overrun on push")
	`CREM_ASSERT_NEXT(a_last_closes_chain, in_fire && last_in, !run_open_q, "chain left open after last cluster")
	`CREM_ASSERT_SAME(a_open_run_counted, run_open_q, run_count_q != '0, "open run with zero count")
	`CREM_ASSERT_NEXT(a_queue_drains, !fst.empty && !out_valid_q, out_valid_q, "queued run not moved to output")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster run extent merger testbench
// Feeds cluster chains into the merger and checks every extent it returns
// against a predictor kept inside the bench, under several register settings
// and with random stalls on both the cluster and the extent channels.
// ----------------------------------------------------------------------------
module tb
	import crem_pkg::*;
();

	// Results pass through the run queue and the output register after the
	// closing word, so this margin is plenty to be sure nothing is in flight.
	localparam int SETTLE_CYCLES = 8;
	// The slowest correct run is far below this: about a thousand words,
	// each with two extents that may wait out a receiver stall.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_WORDS   = 150;

	// One byte extent as the merger reports it.
	typedef struct {
		logic [EXT_W-1:0] offset;
		logic [EXT_W-1:0] length;
		logic             last;
	} extent_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [CLUSTER_W-1:0] cluster = '0;
	logic                 last_in = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [EXT_W-1:0]     extent_offset;
	logic [EXT_W-1:0]     extent_length;
	logic                 last_out;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	// Shadow copy of the registers and of the chain being merged.
	logic [SIZE_W-1:0]    cfg_cluster_bytes = SIZE_RESET;
	logic [AREA_W-1:0]    cfg_area_offset = '0;
	logic [CLUSTER_W-1:0] chain_prev = '0;
	logic [CLUSTER_W-1:0] chain_start = '0;
	logic [COUNT_W-1:0]   chain_len = '0;
	logic                 chain_open = 1'b0;

	// Extents predicted but not yet seen on the output, oldest first.
	extent_t pending_extents[$];

	int errors = 0;
	int words_sent = 0;
	int extents_seen = 0;
	int settings_used = 1;
	int cycles = 0;
	// Chance in percent that either side starts an idle burst; zero gives
	// stretches with no idling at all.
	int idle_pct = 0;
	int stall_left = 0;

	cluster_run_extent_merger_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cluster(cluster),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.extent_offset(extent_offset),
		.extent_length(extent_length),
		.last_out(last_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d extents still expected.",
				cycles, pending_extents.size());
			$display("FAIL");
			$finish;
		end
	end

	// The extent receiver stalls in random bursts.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(3);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic report_field(input string what, input logic [EXT_W-1:0] want,
			input logic [EXT_W-1:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 10)
				$display("Mismatch in %s at %0t: expected %h, got %h", what, $time,
					want, got);
		end
	endtask

	// Every accepted extent word is compared with the oldest prediction.
	always @(posedge clk) begin : check_extent
		extent_t want;
		if (arst_n && out_valid && out_ready) begin
			extents_seen++;
			if (pending_extents.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected extent at %0t: offset %h length %h last %b",
						$time, extent_offset, extent_length, last_out);
			end else begin
				want = pending_extents.pop_front();
				report_field("extent_offset", want.offset, extent_offset);
				report_field("extent_length", want.length, extent_length);
				report_field("last_out", EXT_W'(want.last), EXT_W'(last_out));
			end
		end
	end

	// Byte extent of a run under the registers as they stand now. A zero
	// area offset selects the plain start times size form; otherwise the
	// start is taken relative to cluster two, wrapping for clusters 0 and 1.
	function automatic extent_t extent_of(input logic [CLUSTER_W-1:0] start,
			input logic [COUNT_W-1:0] count, input logic fin);
		logic [EXT_W-1:0] size;
		extent_t e;
		size = EXT_W'(cfg_cluster_bytes);
		if (cfg_area_offset != '0)
			e.offset = EXT_W'(cfg_area_offset) + (EXT_W'(start) - EXT_W'(2)) * size;
		else
			e.offset = EXT_W'(start) * size;
		e.length = EXT_W'(count) * size;
		e.last = fin;
		return e;
	endfunction

	// Append one predicted extent behind those already waiting.
	task automatic expect_extent(input extent_t e);
		pending_extents.insert(pending_extents.size(), e);
	endtask

	// Advance the chain by one cluster and queue whatever extents it closes.
	task automatic merge_cluster(input logic [CLUSTER_W-1:0] c, input logic fin);
		if (!chain_open) begin
			chain_start = c;
			chain_len = COUNT_W'(1);
			chain_open = 1'b1;
		end else if (c - chain_prev == 32'd1) begin
			// The difference wraps, so cluster 0 follows the top cluster.
			if (chain_len != '1)
				chain_len = chain_len + COUNT_W'(1);
		end else begin
			expect_extent(extent_of(chain_start, chain_len, 1'b0));
			chain_start = c;
			chain_len = COUNT_W'(1);
		end
		chain_prev = c;
		if (fin) begin
			expect_extent(extent_of(chain_start, chain_len, 1'b1));
			chain_open = 1'b0;
		end
	endtask

	// Present one cluster word and hold it until the merger takes it. Valid
	// stays high into the next call unless an idle burst follows.
	task automatic send_word(input logic [CLUSTER_W-1:0] c, input logic fin);
		in_valid <= 1'b1;
		cluster <= c;
		last_in <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		merge_cluster(c, fin);
		words_sent++;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Drop valid and let every predicted extent come out before going on.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_extents.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB transfer: setup phase, access phase, then an idle phase so
	// that back-to-back calls never assign psel twice in one step.
	task automatic apb_access(input reg_idx_t idx, input logic wr,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_W'(idx) << 3;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] unused;
		apb_access(idx, 1'b1, value, unused);
		// The write lands at the access edge; values are cut to the register
		// width.
		if (idx == REG_CLUSTER_BYTES)
			cfg_cluster_bytes = value[SIZE_W-1:0];
		else
			cfg_area_offset = value[AREA_W-1:0];
	endtask

	task automatic check_reg(input reg_idx_t idx);
		logic [DATA_W-1:0] got;
		apb_access(idx, 1'b0, '0, got);
		if (idx == REG_CLUSTER_BYTES)
			report_field("cluster_bytes readback", EXT_W'(cfg_cluster_bytes), got);
		else
			report_field("data_area_offset readback", EXT_W'(cfg_area_offset), got);
	endtask

	task automatic set_registers(input logic [DATA_W-1:0] size,
			input logic [DATA_W-1:0] area);
		write_reg(REG_CLUSTER_BYTES, size);
		write_reg(REG_DATA_AREA_OFFSET, area);
		check_reg(REG_CLUSTER_BYTES);
		check_reg(REG_DATA_AREA_OFFSET);
		settings_used++;
	endtask

	task automatic test_reset_registers();
		check_reg(REG_CLUSTER_BYTES);
		check_reg(REG_DATA_AREA_OFFSET);
	endtask

	// Chains of one cluster: the first word both opens and closes the run.
	// The top cluster number checks that the product is not cut at 32 bits.
	task automatic test_single_cluster_chains();
		send_word(32'd2, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'd0, 1'b1);
		wait_drained();
	endtask

	// Runs that merge, runs that break, a break on the final word (two
	// extents from one word), a repeated cluster, and adjacency across the
	// wrap from the top cluster number to zero.
	task automatic test_run_breaks();
		send_word(32'd10, 1'b0);
		send_word(32'd11, 1'b0);
		send_word(32'd12, 1'b1);
		send_word(32'd5, 1'b0);
		send_word(32'd9, 1'b0);
		send_word(32'd20, 1'b1);
		send_word(32'd7, 1'b0);
		send_word(32'd7, 1'b1);
		send_word(32'hFFFF_FFFE, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'd0, 1'b0);
		send_word(32'd1, 1'b1);
		wait_drained();
	endtask

	// All-ones writes show the masking and give the largest size and area.
	// Clusters 0 and 1 then fall below the area start and wrap the sum.
	// A zero cluster size must give zero products without complaint.
	task automatic test_register_extremes();
		set_registers('1, '1);
		send_word(32'd0, 1'b1);
		send_word(32'd1, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'hFFFF_FFFE, 1'b1);
		wait_drained();
		set_registers(64'd0, 64'h1000);
		send_word(32'd40, 1'b0);
		send_word(32'd41, 1'b1);
		wait_drained();
		set_registers(64'd1, 64'd0);
		send_word(32'hFFFF_FFFF, 1'b1);
		wait_drained();
	endtask

	// A register write while a run is open but nothing is in flight: the
	// extent must use the size in force when it is emitted.
	task automatic test_config_mid_chain();
		set_registers(64'd512, 64'h10_0000);
		send_word(32'd100, 1'b0);
		wait_drained();
		write_reg(REG_CLUSTER_BYTES, 64'd4096);
		send_word(32'd101, 1'b0);
		send_word(32'd102, 1'b1);
		wait_drained();
	endtask

	function automatic logic [DATA_W-1:0] pick_size();
		case ($urandom_range(6))
			0: return 64'd1;
			1: return 64'd512;
			2: return 64'd4096;
			3: return 64'd32768;
			4: return 64'h200_0000;
			5: return 64'h3FF_FFFF;
			default: return DATA_W'($urandom_range(32'h3FF_FFFF));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_area();
		case ($urandom_range(3))
			0: return 64'd0;
			1: return 64'hFFFF_FFFF_FFFF;
			2: return DATA_W'($urandom_range(32'hFFFF)) << 9;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [CLUSTER_W-1:0] pick_start();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return $urandom_range(2, 100000);
			6: return $urandom_range(1);
			7: return 32'hFFFF_FFF0 + $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed chains: long stretches of adjacent clusters with
	// the odd jump, repeat or step back, ending on a flagged word. A share
	// of fully random words with a random final flag adds noise.
	task automatic run_chains(input int words);
		int done;
		int len;
		int k;
		int pick;
		logic [CLUSTER_W-1:0] c;
		logic fin;
		done = 0;
		while (done < words) begin
			len = $urandom_range(1, 16);
			c = pick_start();
			for (k = 0; k < len; k++) begin
				fin = (k == len - 1);
				pick = $urandom_range(99);
				if (k != 0) begin
					if (pick < 72)
						c = c + 32'd1;
					else if (pick < 80)
						c = c + $urandom_range(2, 8);
					else if (pick < 85)
						c = c - 32'd1;
					else if (pick < 90)
						c = c;
					else
						c = $urandom;
				end
				if ($urandom_range(99) < 8) begin
					c = $urandom;
					fin = fin | ($urandom_range(1) != 0);
				end
				send_word(c, fin);
				done++;
				if (fin)
					break;
			end
		end
	endtask

	// Several phases under fresh register values, some with idling on both
	// sides and some without; the last phase runs with no idling at all.
	task automatic test_random_chains();
		int p;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				set_registers(64'h3FF_FFFF, 64'hFFFF_FFFF_FFFF);
			else if (p == 1)
				set_registers(64'd1, 64'd0);
			else
				set_registers(pick_size(), pick_area());
			if (p == RANDOM_PHASES - 1 || p % 3 == 1)
				idle_pct = 0;
			else
				idle_pct = 30;
			run_chains(PHASE_WORDS);
			wait_drained();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 30;
		test_reset_registers();
		test_single_cluster_chains();
		test_run_breaks();
		test_register_extremes();
		test_config_mid_chain();
		test_random_chains();
		idle_pct = 0;
		wait_drained();
		$display("Merged %0d cluster words into %0d checked extents.",
			words_sent, extents_seen);
		$display("Covered %0d register settings, including zero, one and the top size.",
			settings_used);
		if (errors == 0 && pending_extents.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d extents missing.", errors,
				pending_extents.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
